// ----- hw/rtl/multiturn_angle_speed_tracker_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn angle and speed tracker
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ANGLE_SPEED_TRACKER_CORE_MACROS_SVH
`define MULTITURN_ANGLE_SPEED_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tracker assertion failed");

`endif

// ----- hw/rtl/mast_pkg.sv -----
// ----------------------------------------------------------------------------
// mast_pkg
// Types and fixed constants shared by the tracker core and its divider.
// ----------------------------------------------------------------------------
package mast_pkg;

	localparam int POS_W   = 32;
	localparam int TIME_W  = 32;
	localparam int SPEED_W = 22;

	// Largest speed magnitudes for each sign, in counts per second.
	localparam logic [31:0] SPEED_POS_LIMIT = 32'd2097151;
	localparam logic [31:0] SPEED_NEG_LIMIT = 32'd2097152;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_PRESET = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- hw/rtl/mast_divider.sv -----
// ----------------------------------------------------------------------------
// mast_divider
// Restoring unsigned divider, one quotient bit per clock, by a 32-bit divisor.
// ----------------------------------------------------------------------------
module mast_divider #(
	parameter int N = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [N-1:0]          dividend,
	input  logic [31:0]           divisor,
	output logic [N-1:0]          quotient,
	output mast_pkg::div_status_t status
);

	localparam int CNT_W = $clog2(N + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [31:0]      rem_q;
	logic [N-1:0]     quo_q;
	logic [31:0]      dsr_q;
	logic [32:0]      trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign trial = {rem_q, quo_q[N-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = cnt_q != '0;
	assign status.done = done_q;

endmodule

// ----- hw/rtl/multiturn_angle_speed_tracker_core.sv -----
// ----------------------------------------------------------------------------
// multiturn_angle_speed_tracker_core
// Unwraps absolute sensor angles into a saturating multi-turn position and
// estimates speed in counts per second from millisecond timestamps.
// ----------------------------------------------------------------------------
// One item is in work at a time and in_ready is high only while the core is
// idle. A sample with nonzero elapsed time waits on the restoring divider,
// which produces one quotient bit of delta * 1000 / dt per clock. Presets
// and the first sample after reset skip the divider; samples with zero
// elapsed time skip it as well. A finished result sits in the output
// register, so the next transaction is accepted while it waits; a later
// result then waits in ST_OUT until the earlier one has left the register.
module multiturn_angle_speed_tracker_core #(
	parameter int ANGLE_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [ANGLE_BITS-1:0]       raw_angle,
	input  logic [31:0]                 time_ms,
	input  logic signed [31:0]          preset_position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          position,
	output logic signed [21:0]          speed,
	output logic signed [ANGLE_BITS:0]  step_delta
);

	localparam int A        = ANGLE_BITS;
	localparam int DIV_BITS = ANGLE_BITS + 9;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DELTA = 3'd1;
	localparam logic [2:0] ST_POS   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic signed [A:0]     HALF_TURN = (A+1)'(1) <<< (A - 1);
	localparam logic signed [A:0]     FULL_TURN = (A+1)'(1) <<< A;
	localparam logic [DIV_BITS-1:0]   MS_PER_S  = DIV_BITS'(1000);

	logic [2:0]                        st_q;
	logic                              func_q;
	logic [A-1:0]                      angle_q;
	logic [mast_pkg::TIME_W-1:0]       time_q;
	logic signed [mast_pkg::POS_W-1:0] preset_q;
	logic signed [A:0]                 delta_q;
	logic [mast_pkg::TIME_W-1:0]       dt_q;

	logic [A-1:0]                      last_angle_q;
	logic [mast_pkg::TIME_W-1:0]       last_time_q;
	logic signed [mast_pkg::POS_W-1:0] pos_q;
	logic signed [mast_pkg::SPEED_W-1:0] last_speed_q;
	logic                              primed_q;

	logic                              out_valid_q;
	logic signed [mast_pkg::POS_W-1:0] out_pos_q;
	logic signed [mast_pkg::SPEED_W-1:0] out_speed_q;
	logic signed [A:0]                 out_delta_q;

	logic signed [A:0]                 diff;
	logic signed [A:0]                 wrapped;
	logic signed [A:0]                 neg_delta;
	logic [A-1:0]                      delta_mag;
	logic [DIV_BITS-1:0]               dividend;
	logic signed [32:0]                pos_sum;
	logic signed [31:0]                pos_next;
	logic [31:0]                       quo_wide;
	logic [mast_pkg::SPEED_W-1:0]      speed_mag;
	logic signed [mast_pkg::SPEED_W-1:0] speed_next;
	logic                              div_start;
	logic [DIV_BITS-1:0]               quotient;
	mast_pkg::div_status_t             div_st;
	logic                              out_free;

	// Wrap the angle change into half a turn either way; both ends are kept.
	always_comb begin
		diff = $signed({1'b0, angle_q}) - $signed({1'b0, last_angle_q});
		priority if (diff > HALF_TURN) begin
			wrapped = diff - FULL_TURN;
		end else if (diff < -HALF_TURN) begin
			wrapped = diff + FULL_TURN;
		end else begin
			wrapped = diff;
		end
	end

	assign neg_delta = -delta_q;
	assign delta_mag = delta_q[A] ? neg_delta[A-1:0] : delta_q[A-1:0];
	assign dividend  = {{(DIV_BITS - A){1'b0}}, delta_mag} * MS_PER_S;

	always_comb begin
		pos_sum = 33'(pos_q) + 33'(delta_q);
		if (pos_sum[32] != pos_sum[31]) begin
			pos_next = pos_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			pos_next = pos_sum[31:0];
		end
	end

	// Clip the quotient magnitude to the signed speed range, then apply the sign.
	always_comb begin
		quo_wide = 32'(quotient);
		if (delta_q[A]) begin
			speed_mag = (quo_wide > mast_pkg::SPEED_NEG_LIMIT) ?
				mast_pkg::SPEED_NEG_LIMIT[mast_pkg::SPEED_W-1:0] :
				quo_wide[mast_pkg::SPEED_W-1:0];
			speed_next = -$signed(speed_mag);
		end else begin
			speed_mag = (quo_wide > mast_pkg::SPEED_POS_LIMIT) ?
				mast_pkg::SPEED_POS_LIMIT[mast_pkg::SPEED_W-1:0] :
				quo_wide[mast_pkg::SPEED_W-1:0];
			speed_next = $signed(speed_mag);
		end
	end

	assign div_start = (st_q == ST_POS) && (dt_q != '0) && !div_st.busy;
	assign out_free  = !out_valid_q || out_ready;

	mast_divider #(
		.N(DIV_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (dt_q),
		.quotient(quotient),
		.status  (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			last_angle_q <= '0;
			last_time_q  <= '0;
			pos_q        <= '0;
			last_speed_q <= '0;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					if (func_q == mast_pkg::FUNC_PRESET) begin
						pos_q        <= preset_q;
						last_angle_q <= angle_q;
						st_q         <= ST_OUT;
					end else if (!primed_q) begin
						last_angle_q <= angle_q;
						last_time_q  <= time_q;
						primed_q     <= 1'b1;
						st_q         <= ST_OUT;
					end else begin
						last_angle_q <= angle_q;
						last_time_q  <= time_q;
						st_q         <= ST_POS;
					end
				end
				ST_POS: begin
					pos_q <= pos_next;
					if (dt_q == '0) begin
						st_q <= ST_OUT;
					end else if (div_start) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						last_speed_q <= speed_next;
						st_q         <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			func_q   <= func;
			angle_q  <= raw_angle;
			time_q   <= time_ms;
			preset_q <= preset_position;
		end
		if (st_q == ST_DELTA) begin
			if (func_q == mast_pkg::FUNC_SAMPLE && primed_q) begin
				delta_q <= wrapped;
			end else begin
				delta_q <= '0;
			end
			dt_q <= time_q - last_time_q;
		end
		if (st_q == ST_OUT && out_free) begin
			out_pos_q   <= pos_q;
			out_speed_q <= last_speed_q;
			out_delta_q <= delta_q;
		end
	end

	assign in_ready   = st_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign position   = out_pos_q;
	assign speed      = out_speed_q;
	assign step_delta = out_delta_q;

endmodule

// ----- hw/rtl/mast_checker.sv -----
// ----------------------------------------------------------------------------
// mast_checker
// Port-level assertions for the tracker core, bound into the core module.
// ----------------------------------------------------------------------------
`include "multiturn_angle_speed_tracker_core_macros.svh"

module mast_checker #(
	parameter int ANGLE_BITS = 12
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [31:0]         position,
	input logic signed [21:0]         speed,
	input logic signed [ANGLE_BITS:0] step_delta
);

	localparam logic signed [ANGLE_BITS:0] HALF_TURN = (ANGLE_BITS+1)'(1) <<< (ANGLE_BITS - 1);

	// The core works on one transaction at a time.
	`MAST_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A reported step never exceeds half a turn in either direction.
	`MAST_ASSERT_SAME(a_step_in_range, clk, arst_n, out_valid,
		(step_delta <= HALF_TURN) && (step_delta >= -HALF_TURN))

	`MAST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	`MAST_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(position) && $stable(speed) && $stable(step_delta))

endmodule

bind multiturn_angle_speed_tracker_core mast_checker #(
	.ANGLE_BITS(ANGLE_BITS)
) u_mast_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.position  (position),
	.speed     (speed),
	.step_delta(step_delta)
);
